@@ rtl/core/ccqe_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccqe_pkg
// Shared constants, codes and pipeline types of the CCQE neutrino energy block.
// ----------------------------------------------------------------------------
package ccqe_pkg;

  localparam int COS_FRAC_BITS = 16;

  localparam int E_W     = 24;
  localparam int D_W     = 16;
  localparam int BIND_W  = 17;
  localparam int W_W     = 20;
  localparam int M2_W    = 34;
  localparam int SQ_W    = 2 * D_W - 1;
  localparam int NORM_W  = 32;
  localparam int DIFF_W  = 2 * E_W;
  localparam int P_W     = E_W;
  localparam int PREM_W  = P_W + 4;
  localparam int WW_W    = 2 * W_W;
  localparam int WE_W    = W_W + E_W;
  localparam int NUM_W   = 47;
  localparam int MAG_W   = NUM_W;
  localparam int CQ_W    = 2 * COS_FRAC_BITS + 1;
  localparam int C_W     = COS_FRAC_BITS + 1;
  localparam int CQP_W   = 2 * C_W;
  localparam int C_REM_W = C_W + 3;
  localparam int PC_W    = P_W + C_W;
  localparam int DEN_W   = COS_FRAC_BITS + 28;
  localparam int DEN_U_W = DEN_W - 1;
  localparam int QT_W    = 33;
  localparam int REM_W   = DEN_U_W + 1;
  localparam int N_W     = MAG_W + COS_FRAC_BITS;
  localparam int CMP_W   = DEN_U_W + QT_W - COS_FRAC_BITS;
  localparam int OUT_W   = 32;
  localparam int ST_W    = 3;

  localparam int STEPS   = 4;
  localparam int A_STEPS = (P_W > 2 * COS_FRAC_BITS) ? P_W : 2 * COS_FRAC_BITS;
  localparam int NA      = (A_STEPS + STEPS - 1) / STEPS;
  localparam int NB      = (C_W + STEPS - 1) / STEPS;
  localparam int NC      = (QT_W + STEPS - 1) / STEPS;

  localparam logic [W_W-1:0]          MASS_N_KEV     = 20'd939565;
  localparam logic signed [NUM_W-1:0] MASS_P_SQ_KEV2 = 47'sd880354345984;
  localparam logic [M2_W-1:0]         MASS_E_SQ_KEV2 = 34'd261121;
  localparam logic [M2_W-1:0]         MASS_MU_SQ_KEV2 = 34'd11163676359;
  localparam logic [BIND_W-1:0]       BIND_RESET     = 17'd30000;

  localparam logic [ST_W-1:0] ST_OK         = 3'd0;
  localparam logic [ST_W-1:0] ST_ZERO_DIR   = 3'd1;
  localparam logic [ST_W-1:0] ST_BELOW_MASS = 3'd2;
  localparam logic [ST_W-1:0] ST_BAD_DEN    = 3'd3;
  localparam logic [ST_W-1:0] ST_SAT        = 3'd4;

  localparam logic [OUT_W-1:0] OUT_POS_MAX = 32'h7FFF_FFFF;
  localparam logic [OUT_W-1:0] OUT_NEG_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [E_W-1:0]        e;
    logic [W_W-1:0]        w;
    logic                  electron;
    logic signed [D_W-1:0] x;
    logic signed [D_W-1:0] y;
    logic signed [D_W-1:0] z;
  } in_stage_t;

  typedef struct packed {
    logic [E_W-1:0]    e;
    logic [W_W-1:0]    w;
    logic              electron;
    logic              z_neg;
    logic [SQ_W-1:0]   xx;
    logic [SQ_W-1:0]   yy;
    logic [SQ_W-1:0]   zz;
    logic [DIFF_W-1:0] e2;
    logic [WW_W-1:0]   ww;
    logic [WE_W-1:0]   we;
  } prod_t;

  typedef struct packed {
    logic [E_W-1:0]          e;
    logic [W_W-1:0]          w;
    logic                    z_neg;
    logic                    zero_dir;
    logic                    below;
    logic signed [NUM_W-1:0] num;
    logic [DIFF_W-1:0]       p_src;
    logic [PREM_W-1:0]       p_rem;
    logic [P_W-1:0]          p_root;
    logic [NORM_W-1:0]       norm;
    logic [NORM_W-1:0]       cd_rem;
    logic [CQP_W-1:0]        cq;
    logic [C_REM_W-1:0]      c_rem;
    logic [C_W-1:0]          c_root;
  } kin_t;

  typedef struct packed {
    logic [E_W-1:0]          e;
    logic [W_W-1:0]          w;
    logic                    z_neg;
    logic                    zero_dir;
    logic                    below;
    logic signed [NUM_W-1:0] num;
    logic [PC_W-1:0]         pc;
  } mul_t;

  typedef struct packed {
    logic zero_dir;
    logic below;
    logic bad_den;
    logic neg;
  } flags_t;

  typedef struct packed {
    flags_t             fl;
    logic [DEN_U_W-1:0] den;
    logic [MAG_W-1:0]   mag;
  } div_in_t;

  typedef struct packed {
    flags_t             fl;
    logic               presat;
    logic [DEN_U_W-1:0] den;
    logic [QT_W-1:0]    n_low;
    logic [REM_W-1:0]   rem;
    logic [QT_W-1:0]    q;
  } div_stage_t;

endpackage

@@ rtl/core/ccqe_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccqe_in_if
// Lepton request channel: valid/ready with energy, direction and flavor.
// ----------------------------------------------------------------------------
interface ccqe_in_if;
  logic                 valid;
  logic                 ready;
  logic [23:0]          lepton_energy_kev;
  logic signed [15:0]   dir_x;
  logic signed [15:0]   dir_y;
  logic signed [15:0]   dir_z;
  logic                 electron_flag;

  modport source (
    output valid, lepton_energy_kev, dir_x, dir_y, dir_z, electron_flag,
    input  ready
  );
  modport sink (
    input  valid, lepton_energy_kev, dir_x, dir_y, dir_z, electron_flag,
    output ready
  );
endinterface

@@ rtl/core/ccqe_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccqe_out_if
// Result channel: valid/ready with neutrino energy and status code.
// ----------------------------------------------------------------------------
interface ccqe_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] neutrino_energy_kev;
  logic [2:0]         status;

  modport source (
    output valid, neutrino_energy_kev, status,
    input  ready
  );
  modport sink (
    input  valid, neutrino_energy_kev, status,
    output ready
  );
endinterface

@@ rtl/core/ccqe_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccqe_div
// Pipelined restoring divider with rounding, saturation and status select.
// ----------------------------------------------------------------------------
module ccqe_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  logic                     in_valid,
  input  ccqe_pkg::div_in_t        in_data,
  output logic                     out_valid,
  output logic [ccqe_pkg::OUT_W-1:0] out_energy,
  output logic [ccqe_pkg::ST_W-1:0]  out_status
);
  import ccqe_pkg::*;

  div_stage_t        d_r   [NC+1];
  div_stage_t        d_nxt [NC+1];
  logic [NC:0]       dv_r;
  logic              ov_r;
  logic [OUT_W-1:0]  oval_r, oval_nxt;
  logic [ST_W-1:0]   ost_r, ost_nxt;

  always_comb begin
    logic [N_W-1:0]   nfull;
    logic [REM_W-1:0] rt;
    div_stage_t       t;
    int               kk;
    nfull = {in_data.mag, {COS_FRAC_BITS{1'b0}}};
    d_nxt[0].fl     = in_data.fl;
    d_nxt[0].den    = in_data.den;
    d_nxt[0].presat = CMP_W'(in_data.mag) >= (CMP_W'(in_data.den) << (QT_W - COS_FRAC_BITS));
    d_nxt[0].n_low  = nfull[QT_W-1:0];
    d_nxt[0].rem    = REM_W'(nfull[N_W-1:QT_W]);
    d_nxt[0].q      = '0;
    for (int i = 0; i < NC; i++) begin
      t = d_r[i];
      for (int j = 0; j < STEPS; j++) begin
        kk = i * STEPS + j;
        if (kk < QT_W) begin
          rt      = {t.rem[REM_W-2:0], t.n_low[QT_W-1]};
          t.n_low = t.n_low << 1;
          if (rt >= REM_W'(t.den)) begin
            t.rem = rt - REM_W'(t.den);
            t.q   = {t.q[QT_W-2:0], 1'b1};
          end else begin
            t.rem = rt;
            t.q   = {t.q[QT_W-2:0], 1'b0};
          end
        end
      end
      d_nxt[i+1] = t;
    end
  end

  always_comb begin
    div_stage_t     f;
    logic           rnd;
    logic [QT_W:0]  qr;
    logic           sat;
    f   = d_r[NC];
    rnd = {f.rem, 1'b0} >= (REM_W + 1)'(f.den);
    qr  = (QT_W + 1)'(f.q) + (QT_W + 1)'(rnd);
    sat = f.presat ||
          (!f.fl.neg && qr > (QT_W + 1)'(OUT_POS_MAX)) ||
          (f.fl.neg && qr > (QT_W + 1)'(OUT_NEG_MIN));
    priority if (f.fl.zero_dir) begin
      ost_nxt  = ST_ZERO_DIR;
      oval_nxt = '0;
    end else if (f.fl.below) begin
      ost_nxt  = ST_BELOW_MASS;
      oval_nxt = '0;
    end else if (f.fl.bad_den) begin
      ost_nxt  = ST_BAD_DEN;
      oval_nxt = '0;
    end else if (sat) begin
      ost_nxt  = ST_SAT;
      oval_nxt = f.fl.neg ? OUT_NEG_MIN : OUT_POS_MAX;
    end else begin
      ost_nxt  = ST_OK;
      oval_nxt = f.fl.neg ? (OUT_W'(0) - qr[OUT_W-1:0]) : qr[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r <= '0;
      ov_r <= 1'b0;
    end else if (adv) begin
      dv_r <= {dv_r[NC-1:0], in_valid};
      ov_r <= dv_r[NC];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i <= NC; i++) begin
        d_r[i] <= d_nxt[i];
      end
      oval_r <= oval_nxt;
      ost_r  <= ost_nxt;
    end
  end

  assign out_valid  = ov_r;
  assign out_energy = oval_r;
  assign out_status = ost_r;

endmodule

@@ rtl/core/ccqe_neutrino_energy_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccqe_neutrino_energy_top
// CCQE neutrino energy reconstruction: lepton momentum, direction cosine and
// energy quotient in a stall-on-output pipeline.
// Throughput: one request per cycle while the result is not held.
// The pipeline depth is set by the digit-serial square roots and dividers,
// four digits per stage; the whole pipeline holds while the result waits.
// Reset clears all valid bits and loads the binding energy with 30000 keV.
// ----------------------------------------------------------------------------
module ccqe_neutrino_energy_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [ccqe_pkg::BIND_W-1:0]   cfg_wr_data,
  ccqe_in_if.sink                       in_ch,
  ccqe_out_if.source                    out_ch
);
  import ccqe_pkg::*;

  logic [BIND_W-1:0] bind_r;
  logic              adv;
  logic              out_valid;

  in_stage_t   s1_r, s1_nxt;
  logic        s1_v_r;
  prod_t       s2_r, s2_nxt;
  logic        s2_v_r;
  kin_t        k_r   [NA+NB+1];
  kin_t        k_nxt [NA+NB+1];
  logic [NA+NB:0] k_v_r;
  mul_t        m_r, m_nxt;
  logic        m_v_r;
  div_in_t     d_r, d_nxt;
  logic        d_v_r;

  assign adv         = !out_valid || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bind_r <= BIND_RESET;
    end else if (cfg_wr_en) begin
      bind_r <= cfg_wr_data;
    end
  end

  always_comb begin
    s1_nxt.e        = in_ch.lepton_energy_kev;
    s1_nxt.w        = MASS_N_KEV - W_W'(bind_r);
    s1_nxt.electron = in_ch.electron_flag;
    s1_nxt.x        = in_ch.dir_x;
    s1_nxt.y        = in_ch.dir_y;
    s1_nxt.z        = in_ch.dir_z;
  end

  always_comb begin
    logic signed [2*D_W-1:0] xs, ys, zs;
    xs = s1_r.x * s1_r.x;
    ys = s1_r.y * s1_r.y;
    zs = s1_r.z * s1_r.z;
    s2_nxt.e        = s1_r.e;
    s2_nxt.w        = s1_r.w;
    s2_nxt.electron = s1_r.electron;
    s2_nxt.z_neg    = s1_r.z[D_W-1];
    s2_nxt.xx       = SQ_W'(xs);
    s2_nxt.yy       = SQ_W'(ys);
    s2_nxt.zz       = SQ_W'(zs);
    s2_nxt.e2       = DIFF_W'(s1_r.e) * DIFF_W'(s1_r.e);
    s2_nxt.ww       = WW_W'(s1_r.w) * WW_W'(s1_r.w);
    s2_nxt.we       = WE_W'(s1_r.w) * WE_W'(s1_r.e);
  end

  always_comb begin
    logic [M2_W-1:0]   m2;
    logic [NORM_W-1:0] norm;
    logic              q0;
    logic [PREM_W-1:0] pt, ptr;
    logic [NORM_W:0]   dt;
    logic [C_REM_W-1:0] ct, ctr;
    kin_t              t;
    int                kk;
    m2   = s2_r.electron ? MASS_E_SQ_KEV2 : MASS_MU_SQ_KEV2;
    norm = NORM_W'(s2_r.xx) + NORM_W'(s2_r.yy) + NORM_W'(s2_r.zz);
    q0   = NORM_W'(s2_r.zz) >= norm;
    k_nxt[0].e        = s2_r.e;
    k_nxt[0].w        = s2_r.w;
    k_nxt[0].z_neg    = s2_r.z_neg;
    k_nxt[0].zero_dir = norm == '0;
    k_nxt[0].below    = s2_r.e2 < DIFF_W'(m2);
    k_nxt[0].num      = MASS_P_SQ_KEV2 - $signed(NUM_W'(s2_r.ww)) - $signed(NUM_W'(m2))
                        + $signed(NUM_W'({s2_r.we, 1'b0}));
    k_nxt[0].p_src    = s2_r.e2 - DIFF_W'(m2);
    k_nxt[0].p_rem    = '0;
    k_nxt[0].p_root   = '0;
    k_nxt[0].norm     = norm;
    k_nxt[0].cd_rem   = q0 ? NORM_W'(s2_r.zz) - norm : NORM_W'(s2_r.zz);
    k_nxt[0].cq       = CQP_W'(q0);
    k_nxt[0].c_rem    = '0;
    k_nxt[0].c_root   = '0;
    for (int i = 0; i < NA; i++) begin
      t = k_r[i];
      for (int j = 0; j < STEPS; j++) begin
        kk = i * STEPS + j;
        if (kk < P_W) begin
          pt      = {t.p_rem[PREM_W-3:0], t.p_src[DIFF_W-1 -: 2]};
          ptr     = PREM_W'({t.p_root, 2'b01});
          t.p_src = t.p_src << 2;
          if (pt >= ptr) begin
            t.p_rem  = pt - ptr;
            t.p_root = {t.p_root[P_W-2:0], 1'b1};
          end else begin
            t.p_rem  = pt;
            t.p_root = {t.p_root[P_W-2:0], 1'b0};
          end
        end
        if (kk < 2 * COS_FRAC_BITS) begin
          dt = {t.cd_rem, 1'b0};
          if (dt >= (NORM_W + 1)'(t.norm)) begin
            t.cd_rem = NORM_W'(dt - (NORM_W + 1)'(t.norm));
            t.cq     = {t.cq[CQP_W-2:0], 1'b1};
          end else begin
            t.cd_rem = dt[NORM_W-1:0];
            t.cq     = {t.cq[CQP_W-2:0], 1'b0};
          end
        end
      end
      k_nxt[i+1] = t;
    end
    for (int i = 0; i < NB; i++) begin
      t = k_r[NA+i];
      for (int j = 0; j < STEPS; j++) begin
        kk = i * STEPS + j;
        if (kk < C_W) begin
          ct   = {t.c_rem[C_REM_W-3:0], t.cq[CQP_W-1 -: 2]};
          ctr  = C_REM_W'({t.c_root, 2'b01});
          t.cq = t.cq << 2;
          if (ct >= ctr) begin
            t.c_rem  = ct - ctr;
            t.c_root = {t.c_root[C_W-2:0], 1'b1};
          end else begin
            t.c_rem  = ct;
            t.c_root = {t.c_root[C_W-2:0], 1'b0};
          end
        end
      end
      k_nxt[NA+1+i] = t;
    end
  end

  always_comb begin
    m_nxt.e        = k_r[NA+NB].e;
    m_nxt.w        = k_r[NA+NB].w;
    m_nxt.z_neg    = k_r[NA+NB].z_neg;
    m_nxt.zero_dir = k_r[NA+NB].zero_dir;
    m_nxt.below    = k_r[NA+NB].below;
    m_nxt.num      = k_r[NA+NB].num;
    m_nxt.pc       = PC_W'(k_r[NA+NB].p_root) * PC_W'(k_r[NA+NB].c_root);
  end

  always_comb begin
    logic signed [DEN_W-1:0] wme, pcs, den;
    wme = $signed(DEN_W'(m_r.w)) - $signed(DEN_W'(m_r.e));
    pcs = m_r.z_neg ? -$signed(DEN_W'(m_r.pc)) : $signed(DEN_W'(m_r.pc));
    den = ((wme <<< COS_FRAC_BITS) + pcs) <<< 1;
    d_nxt.fl.zero_dir = m_r.zero_dir;
    d_nxt.fl.below    = m_r.below;
    d_nxt.fl.bad_den  = den[DEN_W-1] || (den == '0);
    d_nxt.fl.neg      = m_r.num[NUM_W-1];
    d_nxt.den         = den[DEN_U_W-1:0];
    d_nxt.mag         = m_r.num[NUM_W-1] ? MAG_W'(-m_r.num) : MAG_W'(m_r.num);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      k_v_r  <= '0;
      m_v_r  <= 1'b0;
      d_v_r  <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_ch.valid;
      s2_v_r <= s1_v_r;
      k_v_r  <= {k_v_r[NA+NB-1:0], s2_v_r};
      m_v_r  <= k_v_r[NA+NB];
      d_v_r  <= m_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
      for (int i = 0; i <= NA + NB; i++) begin
        k_r[i] <= k_nxt[i];
      end
      m_r <= m_nxt;
      d_r <= d_nxt;
    end
  end

  ccqe_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .in_valid   (d_v_r),
    .in_data    (d_r),
    .out_valid  (out_valid),
    .out_energy (out_ch.neutrino_energy_kev),
    .out_status (out_ch.status)
  );

  assign out_ch.valid = out_valid;

endmodule

@@ tb/ccqe_neutrino_energy_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccqe_neutrino_energy_top_tb
// Self-checking bench for the CCQE neutrino energy pipeline.
// A directed request table and a constrained-by-hand random stream are sent
// over bursty valid/ready traffic against a stalling receiver. Untyped results
// are compared to an in-bench integer model of the energy reconstruction. The
// binding energy register is swept across its extremes between idle phases.
// ----------------------------------------------------------------------------
module ccqe_neutrino_energy_top_tb;
  import ccqe_pkg::*;

  typedef struct {
    logic [E_W-1:0]        e;
    logic signed [D_W-1:0] x;
    logic signed [D_W-1:0] y;
    logic signed [D_W-1:0] z;
    logic                  electron;
    bit                    typed;
    logic signed [OUT_W-1:0] enu;
    logic [ST_W-1:0]       st;
  } lepton_req_t;

  typedef struct {
    logic signed [OUT_W-1:0] enu;
    logic [ST_W-1:0]         st;
  } enu_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [BIND_W-1:0] cfg_wr_data = '0;
  logic [BIND_W-1:0] binding_kev = BIND_RESET;

  ccqe_in_if  in_ch ();
  ccqe_out_if out_ch ();

  ccqe_neutrino_energy_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch.sink),
    .out_ch      (out_ch.source)
  );

  enu_result_t enu_pending_q[$];
  int errors = 0;
  int sent = 0;
  int checked = 0;
  int status_seen[5];
  int burst_left = 0;

  always #5 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.lepton_energy_kev = '0;
    in_ch.dir_x = '0;
    in_ch.dir_y = '0;
    in_ch.dir_z = '0;
    in_ch.electron_flag = 1'b0;
    out_ch.ready = 1'b0;
  end

  function automatic bit [63:0] int_sqrt(input bit [63:0] n);
    bit [63:0] res;
    bit [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // floor(a * 2^s / b); returns 1 when the quotient reaches lim
  function automatic bit shifted_quotient(input bit [63:0] a, input bit [63:0] b,
                                          input int s, input bit [63:0] lim,
                                          output bit [63:0] q, output bit [63:0] r);
    bit [63:0] qq;
    bit [63:0] rr;
    qq = a / b;
    rr = a % b;
    q = 0;
    r = 0;
    if (qq >= lim) return 1'b1;
    for (int i = 0; i < s; i++) begin
      rr <<= 1;
      qq <<= 1;
      if (rr >= b) begin
        rr -= b;
        qq |= 64'd1;
      end
      if (qq >= lim) return 1'b1;
    end
    q = qq;
    r = rr;
    return 1'b0;
  endfunction

  function automatic enu_result_t predict_neutrino_energy(input lepton_req_t rq,
                                                          input logic [BIND_W-1:0] bnd);
    enu_result_t res;
    longint e, x, y, z, m2, w, c, p, num, den;
    bit [63:0] norm, cq, cr, q, r, mag;
    bit neg, ovf;
    e = longint'(rq.e);
    x = longint'(rq.x);
    y = longint'(rq.y);
    z = longint'(rq.z);
    m2 = rq.electron ? longint'(MASS_E_SQ_KEV2) : longint'(MASS_MU_SQ_KEV2);
    w = longint'(MASS_N_KEV) - longint'(bnd);
    norm = x * x + y * y + z * z;
    res.enu = '0;
    res.st = ST_OK;
    if (norm == 0) begin
      res.st = ST_ZERO_DIR;
    end else if (e * e < m2) begin
      res.st = ST_BELOW_MASS;
    end else begin
      p = longint'(int_sqrt(e * e - m2));
      void'(shifted_quotient(z * z, norm, 2 * COS_FRAC_BITS, 64'd1 << 62, cq, cr));
      c = longint'(int_sqrt(cq));
      if (z < 0) c = -c;
      den = 2 * ((w - e) * (longint'(1) << COS_FRAC_BITS) + p * c);
      if (den <= 0) begin
        res.st = ST_BAD_DEN;
      end else begin
        num = longint'(MASS_P_SQ_KEV2) - w * w - m2 + 2 * w * e;
        neg = num < 0;
        mag = neg ? -num : num;
        ovf = shifted_quotient(mag, den, COS_FRAC_BITS, 64'd1 << 40, q, r);
        if (!ovf && 2 * r >= den) q++;
        if (ovf || (!neg && q > 64'd2147483647) || (neg && q > 64'd2147483648)) begin
          res.st = ST_SAT;
          res.enu = neg ? OUT_NEG_MIN : OUT_POS_MAX;
        end else begin
          res.enu = neg ? -q[31:0] : q[31:0];
        end
      end
    end
    return res;
  endfunction

  // receiver: stall pattern cycles between open, light and heavy backpressure
  int rx_mode = 0;
  int rx_left = 0;
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_left = $urandom_range(5, 60);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      0: out_ch.ready <= 1'b1;
      1: out_ch.ready <= ($urandom_range(0, 3) != 0);
      default: out_ch.ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin
    enu_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (enu_pending_q.size() == 0) begin
        $error("unexpected result enu=%0d status=%0d", out_ch.neutrino_energy_kev,
               out_ch.status);
        errors++;
      end else begin
        want = enu_pending_q.pop_front();
        checked++;
        if (out_ch.status < 5) status_seen[out_ch.status]++;
        if (out_ch.neutrino_energy_kev !== want.enu) begin
          $error("neutrino_energy_kev expected %0d actual %0d", want.enu,
                 out_ch.neutrino_energy_kev);
          errors++;
        end
        if (out_ch.status !== want.st) begin
          $error("status expected %0d actual %0d", want.st, out_ch.status);
          errors++;
        end
      end
    end
  end

  task automatic send_request(input lepton_req_t rq);
    enu_result_t want;
    in_ch.valid <= 1'b1;
    in_ch.lepton_energy_kev <= rq.e;
    in_ch.dir_x <= rq.x;
    in_ch.dir_y <= rq.y;
    in_ch.dir_z <= rq.z;
    in_ch.electron_flag <= rq.electron;
    do @(posedge clk); while (!in_ch.ready);
    if (rq.typed) begin
      want.enu = rq.enu;
      want.st = rq.st;
    end else begin
      want = predict_neutrino_energy(rq, binding_kev);
    end
    enu_pending_q = {enu_pending_q, want};
    sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(0, 3) == 0 ? 40 : $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain;
    in_ch.valid <= 1'b0;
    while (enu_pending_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_binding(input logic [BIND_W-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    binding_kev = v;
    @(posedge clk);
  endtask

  function automatic lepton_req_t mk(input int e, input int x, input int y, input int z,
                                     input bit el);
    lepton_req_t rq;
    rq.e = E_W'(e);
    rq.x = D_W'(x);
    rq.y = D_W'(y);
    rq.z = D_W'(z);
    rq.electron = el;
    rq.typed = 0;
    rq.enu = '0;
    rq.st = ST_OK;
    return rq;
  endfunction

  function automatic lepton_req_t mk_typed(input lepton_req_t rq, input logic [ST_W-1:0] st);
    rq.typed = 1;
    rq.st = st;
    rq.enu = '0;
    return rq;
  endfunction

  function automatic lepton_req_t rand_request;
    lepton_req_t rq;
    int k;
    rq = mk(0, $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
    k = $urandom_range(0, 9);
    case (k)
      0: rq.e = E_W'($urandom);
      1: rq.e = E_W'($urandom_range(0, 120000));
      2, 3: rq.e = E_W'($urandom_range(100000, 3000000));
      default: rq.e = E_W'($urandom_range(110000, 1500000));
    endcase
    k = $urandom_range(0, 9);
    if (k < 4) begin
      rq.x = D_W'(int'($urandom_range(0, 800)) - 400);
      rq.y = D_W'(int'($urandom_range(0, 800)) - 400);
      rq.z = D_W'($urandom_range(500, 32767));
    end else if (k == 4) begin
      rq.x = '0;
      rq.y = '0;
      if ($urandom_range(0, 1)) rq.z = '0;
    end else if (k == 5) begin
      rq.x = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      rq.z = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
    end
    return rq;
  endfunction

  lepton_req_t directed[$];

  initial begin
    logic [BIND_W-1:0] phases[6];
    lepton_req_t rq;
    phases = '{BIND_RESET, 17'd0, 17'd100000, 17'h1FFFF, 17'd0, 17'd0};
    phases[4] = BIND_W'($urandom_range(0, 100000));
    phases[5] = BIND_W'($urandom_range(0, 131071));

    directed = {directed, mk_typed(mk(1000000, 0, 0, 0, 0), ST_ZERO_DIR)};
    directed = {directed, mk_typed(mk(24'hFFFFFF, 0, 0, 0, 1), ST_ZERO_DIR)};
    directed = {directed, mk_typed(mk(0, 0, 0, 1, 0), ST_BELOW_MASS)};
    directed = {directed, mk_typed(mk(0, 0, 0, 1, 1), ST_BELOW_MASS)};
    directed = {directed, mk_typed(mk(105658, 3, 4, 5, 0), ST_BELOW_MASS)};
    directed = {directed, mk_typed(mk(510, -1, 0, 0, 1), ST_BELOW_MASS)};
    directed = {directed, mk_typed(mk(24'hFFFFFF, 0, 0, -32768, 1), ST_BAD_DEN)};
    directed = {directed, mk_typed(mk(24'hFFFFFF, 0, 0, -1, 0), ST_BAD_DEN)};
    directed = {directed, mk(105659, 0, 0, 1, 0)};
    directed = {directed, mk(511, 0, 0, 1, 1)};
    directed = {directed, mk(24'hFFFFFF, 0, 0, 32767, 1)};
    directed = {directed, mk(24'hFFFFFF, 0, 0, 32767, 0)};
    directed = {directed, mk(24'hFFFFFF, 32767, -32768, 32767, 0)};
    directed = {directed, mk(1000000, -32768, -32768, -32768, 0)};
    directed = {directed, mk(1000000, 32767, 32767, 32767, 1)};
    directed = {directed, mk(600000, 1, 0, 0, 0)};
    directed = {directed, mk(300000, 0, -32768, 0, 1)};
    directed = {directed, mk(909565, 0, 0, 0, 1)};
    directed = {directed, mk(920000, 1, 0, 0, 1)};
    directed = {directed, mk(2000000, 10, 20, 32767, 0)};
    directed = {directed, mk(200000, 100, -200, -32768, 0)};

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_request(directed[i]);
    drain();

    foreach (phases[ph]) begin
      if (ph != 0) write_binding(phases[ph]);
      for (int n = 0; n < 125; n++) begin
        rq = rand_request();
        send_request(rq);
        if (ph == 2 && n == 60) drain();
      end
      drain();
    end

    $display("%0d requests sent, %0d results checked over 6 binding settings", sent, checked);
    $display("status ok/zero/below/den/sat: %0d/%0d/%0d/%0d/%0d", status_seen[0],
             status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
    if (errors == 0) begin
      $display("[ccqe_neutrino_energy_top] OK");
    end else begin
      $display("[ccqe_neutrino_energy_top] ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[ccqe_neutrino_energy_top] ERROR");
    $finish;
  end

endmodule
